// ----- sv/ple_pkg.sv -----
`default_nettype none

package ple_pkg;

    localparam int CAPACITY   = 16;
    localparam int DUMP_LIMIT = 16;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_FIND   = 3'd3,
        REQ_DUMP   = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_ROTATE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode         mode;
        logic [IW-1:0]      sel;
        logic signed [31:0] data;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    function automatic logic [4:0] pos5(input logic [PW-1:0] x);
        return x[4:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/positional_list_engine.sv -----
`default_nettype none

// channel  valid        ready        payload
// in       i_in_valid   o_in_ready   i_req_type, i_position, i_value
// out      o_out_valid  i_out_ready  o_status, o_out_value, o_out_position, o_last
//
// append, delete and insert update the cell row as the request is accepted; unused codes give no response
// find and dump rotate the row once through all held elements;
// one result per cycle during a dump; the rotation pauses while a result waits
// reset empties the list at once; the element cells themselves are not cleared
// input is taken only between requests and while the output register can load

module positional_list_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_req_type,
    input  wire logic [4:0]         i_position,
    input  wire logic signed [31:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_out_value,
    output logic [4:0]              o_out_position,
    output logic                    o_last
);
    import ple_pkg::*;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_fill, n_fill;
    logic [CW-1:0]      r_step, n_step;
    logic               r_dump, n_dump;
    logic               r_found, n_found;
    logic [CW-1:0]      r_fpos, n_fpos;
    logic signed [31:0] r_val, n_val;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_status, n_status;
    logic signed [31:0] r_out_value, n_out_value;
    logic [4:0]         r_out_pos, n_out_pos;
    logic               r_last, n_last;

    t_cell_cmd          w_cmd;
    logic signed [31:0] w_head;
    logic               w_out_free;
    logic               w_accept;
    logic [PW-1:0]      w_pe;
    logic [PW-1:0]      w_fc;
    logic [PW-1:0]      w_st;
    logic [PW-1:0]      w_lim;
    logic               w_full;
    logic               w_last_step;
    logic               w_emit;
    logic               w_match;

    ple_chain u_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_head (w_head)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_pe   = (i_position == 5'd0) ? PW'(1) : PW'(i_position);
    assign w_fc   = PW'(r_fill);
    assign w_st   = PW'(r_step);
    assign w_full = (w_fc == PW'(CAPACITY));
    assign w_lim  = (w_fc < PW'(DUMP_LIMIT)) ? w_fc : PW'(DUMP_LIMIT);
    assign w_last_step = (w_st + PW'(1) == w_fc);
    assign w_match     = (w_head == r_val);
    assign w_emit      = r_dump ? (w_st < w_lim) : w_last_step;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_step      = r_step;
        n_dump      = r_dump;
        n_found     = r_found;
        n_fpos      = r_fpos;
        n_val       = r_val;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_out_value = r_out_value;
        n_out_pos   = r_out_pos;
        n_last      = r_last;
        w_cmd.mode  = CM_HOLD;
        w_cmd.sel   = w_fc[IW-1:0];
        w_cmd.data  = i_value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_value = i_value;
                    n_out_pos   = 5'd0;
                    n_last      = 1'b1;
                    n_out_valid = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status   = ST_OK;
                                w_cmd.mode = CM_INSERT;
                                w_cmd.sel  = w_fc[IW-1:0];
                                n_fill     = CW'(w_fc + PW'(1));
                                n_out_pos  = pos5(w_fc + PW'(1));
                            end
                        end
                        REQ_DELETE: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pe > w_fc) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_status   = ST_OK;
                                w_cmd.mode = CM_DELETE;
                                w_cmd.sel  = IW'(w_pe - PW'(1));
                                n_fill     = CW'(w_fc - PW'(1));
                                n_out_pos  = pos5(w_pe);
                            end
                        end
                        REQ_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_pe > w_fc + PW'(1)) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_status   = ST_OK;
                                w_cmd.mode = CM_INSERT;
                                w_cmd.sel  = IW'(w_pe - PW'(1));
                                n_fill     = CW'(w_fc + PW'(1));
                                n_out_pos  = pos5(w_pe);
                            end
                        end
                        REQ_FIND: begin
                            if (r_fill == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_state     = S_SCAN;
                                n_dump      = 1'b0;
                                n_step      = '0;
                                n_found     = 1'b0;
                                n_val       = i_value;
                            end
                        end
                        REQ_DUMP: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_state     = S_SCAN;
                                n_dump      = 1'b1;
                                n_step      = '0;
                                n_found     = 1'b0;
                                n_val       = i_value;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !i_out_ready;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!w_emit || w_out_free) begin
                    w_cmd.mode = CM_ROTATE;
                    w_cmd.sel  = IW'(w_fc - PW'(1));
                    w_cmd.data = w_head;
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        if (r_dump) begin
                            n_status    = ST_OK;
                            n_out_value = w_head;
                            n_out_pos   = pos5(w_st + PW'(1));
                            n_last      = (w_st + PW'(1) == w_lim);
                        end else begin
                            n_out_value = r_val;
                            n_last      = 1'b1;
                            if (r_found) begin
                                n_status  = ST_OK;
                                n_out_pos = pos5(PW'(r_fpos));
                            end else if (w_match) begin
                                n_status  = ST_OK;
                                n_out_pos = pos5(w_st + PW'(1));
                            end else begin
                                n_status  = ST_NOT_FOUND;
                                n_out_pos = 5'd0;
                            end
                        end
                    end
                    if (!r_dump && w_match && !r_found) begin
                        n_found = 1'b1;
                        n_fpos  = CW'(w_st + PW'(1));
                    end
                    if (w_last_step) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = CW'(w_st + PW'(1));
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_dump      <= n_dump;
        r_found     <= n_found;
        r_fpos      <= n_fpos;
        r_val       <= n_val;
        r_status    <= n_status;
        r_out_value <= n_out_value;
        r_out_pos   <= n_out_pos;
        r_last      <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_position = r_out_pos;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ----- sv/ple_cell.sv -----
`default_nettype none

module ple_cell (
    input  wire logic                  i_clk,
    input  wire ple_pkg::t_cell_cmd    i_cmd,
    input  wire logic [ple_pkg::IW-1:0] i_idx,
    input  wire logic signed [31:0]    i_left,
    input  wire logic signed [31:0]    i_right,
    output logic signed [31:0]         o_value
);
    import ple_pkg::*;

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.mode)
            CM_INSERT: begin
                if (i_idx == i_cmd.sel) begin
                    n_value = i_cmd.data;
                end else if (i_idx > i_cmd.sel) begin
                    n_value = i_left;
                end
            end
            CM_DELETE: begin
                if (i_idx >= i_cmd.sel) begin
                    n_value = i_right;
                end
            end
            CM_ROTATE: begin
                if (i_idx == i_cmd.sel) begin
                    n_value = i_cmd.data;
                end else if (i_idx < i_cmd.sel) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- sv/ple_chain.sv -----
`default_nettype none

module ple_chain (
    input  wire logic               i_clk,
    input  wire ple_pkg::t_cell_cmd i_cmd,
    output logic signed [31:0]      o_head
);
    import ple_pkg::*;

    logic signed [31:0] w_val [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_val[g];
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_idx   (IW'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[g])
        );
    end

    assign o_head = w_val[0];

endmodule

`default_nettype wire
